// ===== rtl/crc8pf_pkg.sv =====
// Types, constants and the CRC-8 step function shared by the packet framer modules.
package crc8pf_pkg;

  localparam logic [7:0] SYNC_HI_BYTE = 8'h5A;
  localparam logic [7:0] SYNC_LO_BYTE = 8'hA5;
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] CRC_INIT     = 8'h00;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_CODE = 8'd1;

  localparam logic [7:0] DEST_ADDRESS_RESET = 8'd0;
  localparam logic [7:0] COMMAND_CODE_RESET = 8'd116;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } result_t;

  // Classified item as held in the queue
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       first_byte;
    logic       last_byte;
    logic       has_data;
  } entry_t;

  // MSB-first CRC-8, no reflection, no final xor
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/crc8pf_front.sv =====
// Front end: accepts input items, classifies them and drops those that give no output.
module crc8pf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  crc8pf_pkg::item_t item,
  output logic              push,
  output crc8pf_pkg::entry_t push_entry,
  input  logic              q_ready
);
  import crc8pf_pkg::*;

  logic   stage_valid;
  entry_t stage;
  entry_t classified;
  logic   accept;
  logic   empty_item;

  always_comb begin
    classified.payload_byte   = item.payload_byte;
    classified.payload_length = item.payload_length;
    classified.first_byte     = item.first_byte;
    classified.last_byte      = item.last_byte;
    classified.has_data       = (item.payload_length != 8'd0);
    empty_item = !item.first_byte && !item.last_byte && !classified.has_data;
  end

  assign item_ready = !stage_valid || q_ready;
  assign accept     = item_valid && item_ready;
  assign push       = stage_valid && q_ready;
  assign push_entry = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      // drop items that carry no byte, no header and no CRC
      stage_valid <= !empty_item;
    end else if (q_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= classified;
    end
  end

endmodule

// ===== rtl/crc8pf_queue.sv =====
// Short FIFO of classified items between the front end and the frame sequencer.
module crc8pf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crc8pf_pkg::entry_t push_entry,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output crc8pf_pkg::entry_t head
);
  import crc8pf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_ready = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/crc8pf_back.sv =====
// Frame sequencer: expands queued items into header, payload and CRC bytes.
module crc8pf_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crc8pf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                           cfg_data,
  input  logic                                 q_valid,
  input  crc8pf_pkg::entry_t                   head,
  output logic                                 pop,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output crc8pf_pkg::result_t                  res
);
  import crc8pf_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC_HI,
    PH_SYNC_LO,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_t;

  logic       busy;
  phase_t     phase;
  logic [7:0] running_crc;
  logic [7:0] dest_address;
  logic [7:0] command_code;

  phase_t     cur;
  phase_t     phase_next;
  logic [7:0] crc_next;
  logic [7:0] byte_next;
  logic       done;
  logic       step;

  assign cfg_ready = 1'b1;
  assign step      = q_valid && (!res_valid || res_ready);
  assign pop       = step && done;

  always_comb begin
    if (busy) begin
      cur = phase;
    end else if (head.first_byte) begin
      cur = PH_SYNC_HI;
    end else if (head.has_data) begin
      cur = PH_DATA;
    end else begin
      cur = PH_CRC;
    end

    crc_next   = running_crc;
    byte_next  = running_crc;
    phase_next = PH_CRC;
    done       = 1'b0;

    unique case (cur)
      PH_SYNC_HI: begin
        byte_next  = SYNC_HI_BYTE;
        phase_next = PH_SYNC_LO;
      end
      PH_SYNC_LO: begin
        byte_next  = SYNC_LO_BYTE;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        // restart the CRC at the head of every frame
        byte_next  = dest_address;
        crc_next   = crc_feed(CRC_INIT, dest_address);
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        byte_next  = command_code;
        crc_next   = crc_feed(running_crc, command_code);
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        byte_next = head.payload_length;
        crc_next  = crc_feed(running_crc, head.payload_length);
        if (head.has_data) begin
          phase_next = PH_DATA;
        end else if (head.last_byte) begin
          phase_next = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_DATA: begin
        byte_next = head.payload_byte;
        crc_next  = crc_feed(running_crc, head.payload_byte);
        done      = !head.last_byte;
      end
      PH_CRC: begin
        byte_next = running_crc;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      phase        <= PH_SYNC_HI;
      running_crc  <= CRC_INIT;
      res_valid    <= 1'b0;
      dest_address <= DEST_ADDRESS_RESET;
      command_code <= COMMAND_CODE_RESET;
    end else begin
      if (cfg_valid && cfg_index == REG_DEST_ADDRESS) begin
        dest_address <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_COMMAND_CODE) begin
        command_code <= cfg_data;
      end
      if (step) begin
        busy        <= !done;
        phase       <= phase_next;
        running_crc <= crc_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.out_byte  <= byte_next;
      res.run_last  <= done;
      res.frame_end <= (cur == PH_CRC);
    end
  end

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.run_last)
    else $error("closing CRC byte not marked as last result of its item");

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid)
    else $error("sequencer mid-item with an empty queue");

  a_data_phase_has_byte: assert property (@(posedge clk) disable iff (rst)
    busy && phase == PH_DATA |-> head.has_data)
    else $error("payload phase entered for an item of zero length");

  a_crc_phase_is_last: assert property (@(posedge clk) disable iff (rst)
    busy && phase == PH_CRC |-> head.last_byte)
    else $error("CRC phase entered for an item without the last flag");

endmodule

// ===== rtl/crc8_packet_framer.sv =====
// Packet framer top level: sync header, address, command, length, payload and CRC-8.
// A payload item with neither flag set gives one output byte; the block takes a new item
// every cycle while such items flow and the output is not stalled. A first item adds the
// sync bytes, address, command and length, and a last item the CRC byte; these come from
// the frame sequencer, which emits one frame byte per cycle into its output register while
// the queue holds an item and the output is not stalled. Items with neither flag and zero
// length give no output and are dropped at the front end. Input passes the front stage,
// queue and output register; the queue of QUEUE_DEPTH items lets input keep flowing during
// header and CRC bursts. The CRC is polynomial 0x07, initial value 0, MSB first, over
// address, command, length and payload. Configuration writes are taken every cycle.
module crc8_packet_framer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crc8pf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                          cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  crc8pf_pkg::item_t                   item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output crc8pf_pkg::result_t                 res
);
  import crc8pf_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_ready;
  logic   q_valid;
  entry_t head;
  logic   pop;

  crc8pf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  crc8pf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  crc8pf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
